// File: design/integer_to_radix_ascii_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Checked on every clock edge outside reset.
`define I2RA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, also during reset.
`define I2RA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/i2ra_pkg.sv
package i2ra_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = $clog2(2 * VALUE_BITS);
  localparam int POS_W      = $clog2(VALUE_BITS);

  localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = DIGIT_W'(36);
  localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] RADIX_DEC   = DIGIT_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE     = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_LETTER_A = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_LETTER_Z = CHAR_W'(122);
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = CHAR_W'(45);

  typedef logic [DIGIT_W-1:0]   digit_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RADIX  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_SIGNED = cfg_idx_t'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Bit-step token that travels one cell per cycle along the row.
  typedef struct packed {
    logic vld;
    logic carry;
  } step_t;

  // Row-wide controls from the sequencer.
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
    logic [CHAR_W-1:0] dw;
    dw = {1'b0, d};
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + dw;
    end else begin
      return CHAR_LETTER_A + dw - CHAR_W'(10);
    end
  endfunction

endpackage

// File: design/i2ra_cell.sv
module i2ra_cell import i2ra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  digit_t    radix,
  input  step_t     step_in,
  input  digit_t    dig_below,
  output step_t     step_out,
  output digit_t    digit
);

  digit_t              digit_r;
  digit_t              digit_nxt;
  step_t               step_r;
  step_t               step_nxt;
  logic [DIGIT_W:0]    dbl;
  logic [DIGIT_W:0]    diff;
  logic                ge;

  // One doubling step of the radix-r digit: 2*d + carry, reduced by r once.
  always_comb begin
    dbl  = {digit_r, step_in.carry};
    diff = dbl - {1'b0, radix};
    ge   = (dbl >= {1'b0, radix});
  end

  always_comb begin
    step_nxt.vld   = step_in.vld;
    step_nxt.carry = step_in.vld & ge;
    priority if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = dig_below;
    end else if (step_in.vld) begin
      digit_nxt = ge ? diff[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign step_out = step_r;
  assign digit    = digit_r;

endmodule

// File: design/i2ra_ctrl.sv
module i2ra_ctrl import i2ra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [DIGIT_W-1:0]    cfg_data,
  output cell_ctl_t             cell_ctl,
  output digit_t                radix,
  output step_t                 feed,
  input  step_t                 tail,
  input  digit_t                top_digit
);

  localparam logic [CNT_W-1:0] CNT_FEED = CNT_W'(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(2 * VALUE_BITS - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(VALUE_BITS - 1);

  state_t                  state_r;
  state_t                  state_nxt;
  logic [VALUE_BITS-1:0]   val_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [POS_W-1:0]        pos_r;
  logic                    neg_r;
  logic                    lead_r;
  digit_t                  radix_r;
  logic                    smode_r;
  logic                    out_valid_r;
  logic [CHAR_W-1:0]       out_char_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    conv_done;
  logic                    slot_free;
  logic                    emit_minus;
  logic                    emit_dig;
  logic                    skip;
  logic                    in_neg;
  logic [VALUE_BITS-1:0]   mag;
  digit_t                  radix_clamped;

  always_comb begin
    in_neg = smode_r && (radix_r == RADIX_DEC) && in_value[VALUE_BITS-1];
    mag    = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
    priority if (cfg_data < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (cfg_data > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = cfg_data;
    end
  end

  // The conversion is over once the token wave has left the last cell.
  assign conv_done = (cnt_r == CNT_DONE) && tail.vld;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_dig && (pos_r == POS_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    accept         = in_ready && in_valid;
    feed.vld       = (state_r == ST_CONV) && (cnt_r < CNT_FEED);
    feed.carry     = val_r[VALUE_BITS-1];
    emit_minus     = (state_r == ST_EMIT) && neg_r && slot_free;
    skip           = (state_r == ST_EMIT) && !neg_r && lead_r &&
                     (top_digit == '0) && (pos_r != POS_LAST);
    emit_dig       = (state_r == ST_EMIT) && !neg_r && !skip && slot_free;
    cell_ctl.clr   = accept;
    cell_ctl.shift = skip || emit_dig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      smode_r     <= 1'b1;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      lead_r      <= 1'b1;
      cnt_r       <= '0;
      pos_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_RADIX) begin
          radix_r <= radix_clamped;
        end else if (cfg_index == CFG_SIGNED) begin
          smode_r <= cfg_data[0];
        end
      end
      if (accept) begin
        neg_r  <= in_neg;
        lead_r <= 1'b1;
        cnt_r  <= '0;
        pos_r  <= '0;
      end else if (state_r == ST_CONV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (emit_minus) begin
        neg_r <= 1'b0;
      end
      if (cell_ctl.shift) begin
        pos_r <= pos_r + POS_W'(1);
      end
      if (emit_dig) begin
        lead_r <= 1'b0;
      end
      if (slot_free) begin
        out_valid_r <= emit_minus || emit_dig;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= mag;
    end else if (state_r == ST_CONV) begin
      val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
    end
    if (emit_minus) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (emit_dig) begin
      out_char_r <= digit_char(top_digit);
      out_last_r <= (pos_r == POS_LAST);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign cfg_ready     = 1'b1;
  assign radix         = radix_r;

endmodule

// File: design/integer_to_radix_ascii.sv
// After an item is accepted, the bit-step wave crosses the 32-cell chain to complete the digit
// row; the row is then shifted out toward the top cell to form the characters.
// The block takes one item at a time (in_ready only while idle), set by that wave and by
// shifting the digit row out one cell per cycle, a digit waiting while the output is held back.
// Reset (synchronous, active low) sets radix to 10 and signed mode on, and empties the output.
module integer_to_radix_ascii import i2ra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [DIGIT_W-1:0]    cfg_data
);

  cell_ctl_t cell_ctl;
  digit_t    radix;
  step_t     step_w [VALUE_BITS+1];
  digit_t    dig_w  [VALUE_BITS];

  i2ra_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_ctl      (cell_ctl),
    .radix         (radix),
    .feed          (step_w[0]),
    .tail          (step_w[VALUE_BITS]),
    .top_digit     (dig_w[VALUE_BITS-1])
  );

  // Cell 0 holds the least significant digit; the row shifts toward the top on output.
  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
    digit_t below;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = dig_w[i-1];
    end
    i2ra_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .radix     (radix),
      .step_in   (step_w[i]),
      .dig_below (below),
      .step_out  (step_w[i+1]),
      .digit     (dig_w[i])
    );
  end

endmodule

// File: design/i2ra_checker.sv
`include "integer_to_radix_ascii_defines.svh"

module i2ra_checker import i2ra_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  `I2RA_ASSERT_RST(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken during conversion")
  `I2RA_ASSERT_RST(a_busy_mid_string, (out_valid && !out_last) |-> !in_ready, "input ready inside a string")
  `I2RA_ASSERT_RST(a_minus_not_last, (out_valid && (out_character == CHAR_MINUS)) |-> !out_last, "minus sign marked last")
  `I2RA_ASSERT_RST(a_char_range, out_valid |-> ((out_character == CHAR_MINUS) || ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)) || ((out_character >= CHAR_LETTER_A) && (out_character <= CHAR_LETTER_Z))), "character out of range")
  `I2RA_ASSERT_ALL(a_out_hold, (rst_n && out_valid && !out_ready) |=> (!rst_n || (out_valid && $stable(out_character) && $stable(out_last))), "stalled item changed")

endmodule

bind integer_to_radix_ascii i2ra_checker u_i2ra_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last      (out_last)
);

// File: tb/integer_to_radix_ascii_test.sv
module integer_to_radix_ascii_test;
  import i2ra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 22;
  localparam int SETTLE_CYCLES = 3 * VALUE_BITS + 8;
  localparam int PRINT_CAP = 100;

  localparam cfg_idx_t CFG_UNUSED_2 = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_UNUSED_3 = cfg_idx_t'(3);

  typedef enum logic {
    ROW_CFG,
    ROW_VALUE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [VALUE_BITS-1:0] data;
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } ascii_char_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_RADIX;
  logic [DIGIT_W-1:0]    cfg_data = '0;

  ascii_char_t        pending_chars[$];
  ascii_char_t        next_char;
  stim_row_t          stim_rows[$];
  string              stim_text[$];
  logic [DIGIT_W-1:0] radix_cfg = RADIX_RESET;
  logic               signed_cfg = 1'b1;
  bit                 quiet = 1'b0;
  int                 mismatches = 0;
  int                 cycle_count = 0;

  integer_to_radix_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               pending_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 23);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b", out_character,
                                  out_last));
      end else begin
        next_char = pending_chars.pop_front();
        if (out_character !== next_char.ch || out_last !== next_char.last) begin
          report_mismatch($sformatf("got 0x%02h last %0b, wanted 0x%02h last %0b",
                                    out_character, out_last, next_char.ch, next_char.last));
        end
      end
    end
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(0, 99) < 23);
  endfunction

  function automatic void apply_register(input cfg_idx_t idx, input logic [DIGIT_W-1:0] data);
    case (idx)
      CFG_RADIX: begin
        if (data < RADIX_MIN) begin
          radix_cfg = RADIX_MIN;
        end else if (data > RADIX_MAX) begin
          radix_cfg = RADIX_MAX;
        end else begin
          radix_cfg = data;
        end
      end
      CFG_SIGNED: begin
        signed_cfg = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  // Digits are collected least significant first and then sent in reverse.
  function automatic void ascii_of_word(input logic [VALUE_BITS-1:0] word);
    logic [VALUE_BITS-1:0] rest;
    logic [DIGIT_W-1:0]    digit_q[$];
    logic [DIGIT_W-1:0]    d;
    logic [CHAR_W-1:0]     c;
    rest = word;
    if (signed_cfg && radix_cfg == RADIX_DEC && word[VALUE_BITS-1]) begin
      pending_chars.push_back({CHAR_MINUS, 1'b0});
      rest = -word;
    end
    do begin
      digit_q.push_front(DIGIT_W'(rest % radix_cfg));
      rest = rest / radix_cfg;
    end while (rest != 0);
    while (digit_q.size() != 0) begin
      d = digit_q.pop_front();
      if (d < 10) begin
        c = CHAR_ZERO + CHAR_W'(d);
      end else begin
        c = CHAR_LETTER_A + CHAR_W'(d) - CHAR_W'(10);
      end
      pending_chars.push_back({c, digit_q.size() == 0});
    end
  endfunction

  task automatic push_text(input string txt);
    byte b;
    for (int i = 0; i < txt.len(); i++) begin
      b = txt[i];
      pending_chars.push_back({b[CHAR_W-1:0], i == txt.len() - 1});
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [DIGIT_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic offer_value(input logic [VALUE_BITS-1:0] v);
    if (take_break()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_row(input row_kind_t kind, input cfg_idx_t idx,
                         input logic [VALUE_BITS-1:0] data, input string txt);
    stim_rows.push_back({kind, idx, data});
    stim_text.push_back(txt);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [63:0] p;
    int          steps;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return $urandom_range(0, 1000);
      4: return $urandom_range(0, 35);
      5, 6: begin
        p = 1;
        steps = $urandom_range(1, VALUE_BITS);
        repeat (steps) begin
          if (p * radix_cfg <= 64'hFFFF_FFFF) begin
            p = p * radix_cfg;
          end
        end
        return VALUE_BITS'(p + 64'($urandom_range(0, 2)) - 64'd1);
      end
      7: return {1'b1, (VALUE_BITS - 1)'($urandom)};
      8: return {VALUE_BITS{1'b1}} - VALUE_BITS'($urandom_range(0, 3));
      default: return {1'b1, {(VALUE_BITS - 1){1'b0}}} + VALUE_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [DIGIT_W-1:0] phase_radix(input int phase);
    case (phase)
      0: return 10;
      1: return 2;
      2: return 36;
      3: return 63;
      4: return 10;
      5: return 16;
      6: return 1;
      7: return 7;
      default: return DIGIT_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    stim_row_t             row;
    string                 txt;
    logic [VALUE_BITS-1:0] word;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(ROW_VALUE, CFG_RADIX, 32'h0000_0000, "0");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFF, "-1");
    add_row(ROW_VALUE, CFG_RADIX, 32'h8000_0000, "-2147483648");
    add_row(ROW_VALUE, CFG_RADIX, 32'h7FFF_FFFF, "2147483647");
    add_row(ROW_VALUE, CFG_RADIX, 32'd9, "9");
    add_row(ROW_VALUE, CFG_RADIX, 32'd10, "10");
    add_row(ROW_VALUE, CFG_RADIX, 32'd12345, "");
    add_row(ROW_CFG, CFG_SIGNED, 32'd0, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFF, "4294967295");
    add_row(ROW_VALUE, CFG_RADIX, 32'h8000_0000, "2147483648");
    add_row(ROW_CFG, CFG_RADIX, 32'd0, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFF, "11111111111111111111111111111111");
    add_row(ROW_VALUE, CFG_RADIX, 32'h0000_0000, "0");
    add_row(ROW_CFG, CFG_SIGNED, 32'd63, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'h8000_0000, "10000000000000000000000000000000");
    add_row(ROW_CFG, CFG_RADIX, 32'd1, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'd5, "101");
    add_row(ROW_CFG, CFG_RADIX, 32'd63, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFF, "1z141z3");
    add_row(ROW_VALUE, CFG_RADIX, 32'd35, "z");
    add_row(ROW_CFG, CFG_RADIX, 32'd37, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'd36, "10");
    add_row(ROW_CFG, CFG_RADIX, 32'd16, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hDEAD_BEEF, "deadbeef");
    add_row(ROW_VALUE, CFG_RADIX, 32'h8000_0000, "80000000");
    add_row(ROW_CFG, CFG_RADIX, 32'd8, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFF, "37777777777");
    add_row(ROW_CFG, CFG_UNUSED_2, 32'd2, "");
    add_row(ROW_CFG, CFG_UNUSED_3, 32'd0, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'd8, "10");
    add_row(ROW_CFG, CFG_RADIX, 32'd10, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'hFFFF_FFFE, "-2");
    add_row(ROW_VALUE, CFG_RADIX, 32'h4996_02D2, "");
    add_row(ROW_CFG, CFG_SIGNED, 32'd62, "");
    add_row(ROW_VALUE, CFG_RADIX, 32'h8000_0001, "");

    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      txt = stim_text.pop_front();
      if (row.kind == ROW_CFG) begin
        write_register(row.idx, row.data[DIGIT_W-1:0]);
      end else begin
        offer_value(row.data);
        if (txt.len() == 0) begin
          ascii_of_word(row.data);
        end else begin
          push_text(txt);
        end
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      write_register(CFG_RADIX, phase_radix(phase));
      if (phase == PHASES - 1) begin
        write_register(CFG_SIGNED, DIGIT_W'($urandom_range(0, 63)));
      end else begin
        write_register(CFG_SIGNED, (phase == 2 || phase == 4 || phase == 7) ? 6'd0 : 6'd1);
      end
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender back until the output has caught up completely.
        if (phase == 5 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        word = pick_value();
        offer_value(word);
        ascii_of_word(word);
      end
      quiet = 1'b0;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/i2ra_pkg.sv
design/i2ra_cell.sv
design/i2ra_ctrl.sv
design/integer_to_radix_ascii.sv
design/i2ra_checker.sv
tb/integer_to_radix_ascii_test.sv
